### hw/rtl/ghbe_pkg.sv
// Shared constants, types and constant tables of the Gauss-Hermite basis evaluator.
package ghbe_pkg;

    localparam int MAX_ORDER_DEF = 9;
    localparam int CFG_W         = 4;
    localparam int COORD_W       = 16;
    localparam int WS_W          = 24;
    localparam int VAL_W         = 16;
    localparam int IDX_W         = 6;
    localparam int MUL_A_W       = 33;
    localparam int MUL_B_W       = 24;
    localparam int PROD_W        = MUL_A_W + MUL_B_W;
    localparam int P_W           = 26;

    localparam logic [CFG_W-1:0]   ORDER_RST  = 4'd4;
    localparam logic [MUL_B_W-1:0] NORM_Q22   = 24'd3150449;
    localparam logic [MUL_B_W-1:0] HALF_LOG2E = 24'd47274;

    // Operand pair for the shared multiplier.
    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

    // sqrt(2/n) in Q.20.
    function automatic logic [21:0] rom_a(input logic [3:0] n);
        logic [21:0] r;
        unique case (n)
            4'd1:    r = 22'd1482910;
            4'd2:    r = 22'd1048576;
            4'd3:    r = 22'd856159;
            4'd4:    r = 22'd741455;
            4'd5:    r = 22'd663178;
            4'd6:    r = 22'd605396;
            4'd7:    r = 22'd560487;
            4'd8:    r = 22'd524288;
            4'd9:    r = 22'd494303;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

    // sqrt((n-1)/n) in Q.20.
    function automatic logic [21:0] rom_b(input logic [3:0] n);
        logic [21:0] r;
        unique case (n)
            4'd2:    r = 22'd741455;
            4'd3:    r = 22'd856159;
            4'd4:    r = 22'd908093;
            4'd5:    r = 22'd937875;
            4'd6:    r = 22'd957215;
            4'd7:    r = 22'd970793;
            4'd8:    r = 22'd980853;
            4'd9:    r = 22'd988607;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

    // Taylor coefficients of 2^-f in Q.24.
    function automatic logic [24:0] taylor_c(input logic [2:0] t);
        logic [24:0] r;
        unique case (t)
            3'd0:    r = 25'd16777216;
            3'd1:    r = 25'd11629080;
            3'd2:    r = 25'd4030332;
            3'd3:    r = 25'd931204;
            3'd4:    r = 25'd161365;
            3'd5:    r = 25'd22370;
            3'd6:    r = 25'd2584;
            default: r = 25'd256;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/ghbe_ifs.sv
// Channel interfaces: point input, basis output and order configuration.
interface ghbe_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [ghbe_pkg::COORD_W-1:0]     x_coord;
    logic signed [ghbe_pkg::COORD_W-1:0]     y_coord;
    modport source(output valid, x_coord, y_coord, input ready);
    modport sink(input valid, x_coord, y_coord, output ready);
endinterface

interface ghbe_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [ghbe_pkg::VAL_W-1:0]       basis_value;
    logic [ghbe_pkg::IDX_W-1:0]              packed_index;
    logic                                    last_of_point;
    modport source(output valid, basis_value, packed_index, last_of_point, input ready);
    modport sink(input valid, basis_value, packed_index, last_of_point, output ready);
endinterface

interface ghbe_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [ghbe_pkg::CFG_W-1:0]              max_total_order;
    modport source(output valid, max_total_order, input ready);
    modport sink(input valid, max_total_order, output ready);
endinterface

### hw/rtl/gauss_hermite_basis_eval_2d_top.sv
// Top level of the 2-D Gauss-Hermite basis evaluator.
//
// Channel   Dir  Payload                                          Item
// i_in      in   x_coord, y_coord (Q4.12)                         one point
// o_out     out  basis_value (Q1.15), packed_index, last_of_point one basis product
// i_cfg     in   max_total_order                                  order register write
//
// With N the clamped order, each point runs a seed and N recurrence orders per axis
// and then emits (N+1)*(N+2)/2 basis products. All arithmetic runs through one
// shared multiplier, used by the seed states, the recurrence states and the product
// states. i_in is ready only between points. A stalled output holds the sequencer
// in place. Reset is synchronous; the order register resets to 4.
module gauss_hermite_basis_eval_2d_top #(
    parameter int MAX_ORDER = ghbe_pkg::MAX_ORDER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ghbe_in_if.sink     i_in,
    ghbe_out_if.source  o_out,
    ghbe_cfg_if.sink    i_cfg
);

    logic [ghbe_pkg::CFG_W-1:0]          r_order_cfg;
    ghbe_pkg::t_mul_req                  mul_req;
    logic signed [ghbe_pkg::PROD_W-1:0]  mul_p;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_cfg <= ghbe_pkg::ORDER_RST;
        end else if (i_cfg.valid) begin
            r_order_cfg <= i_cfg.max_total_order;
        end
    end

    ghbe_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .o_p   (mul_p)
    );

    ghbe_seq #(
        .MAX_ORDER (MAX_ORDER)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_order   (r_order_cfg),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_mul_req (mul_req),
        .i_mul_p   (mul_p)
    );

endmodule

### hw/rtl/ghbe_mul.sv
// Shared signed multiplier with a registered product.
module ghbe_mul (
    input  logic                                   i_clk,
    input  ghbe_pkg::t_mul_req                     i_req,
    output logic signed [ghbe_pkg::PROD_W-1:0]     o_p
);

    logic signed [ghbe_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_req.a * i_req.b;
    end

    assign o_p = r_p;

endmodule

### hw/rtl/ghbe_seq.sv
// Sequencer: seed, recurrence per axis, axis workspaces and product emission.
module ghbe_seq #(
    parameter int MAX_ORDER = ghbe_pkg::MAX_ORDER_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [ghbe_pkg::CFG_W-1:0]             i_order,
    ghbe_in_if.sink                                i_in,
    ghbe_out_if.source                             o_out,
    output ghbe_pkg::t_mul_req                     o_mul_req,
    input  logic signed [ghbe_pkg::PROD_W-1:0]     i_mul_p
);

    localparam int DEPTH = MAX_ORDER + 1;
    localparam int IW    = $clog2(MAX_ORDER + 2);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_LOG, S_UF, S_TMUL, S_TACC, S_SMUL, S_SEED,
        S_R1, S_R2, S_R3, S_R4, S_R5, S_EPRE, S_EMUL, S_EOUT
    } t_state;

    t_state r_state, n_state;
    logic signed [ghbe_pkg::COORD_W-1:0] r_x, n_x, r_y, n_y;
    logic                                r_ax, n_ax;
    logic [IW-1:0]                       r_order, n_order;
    logic [6:0]                          r_k, n_k;
    logic [15:0]                         r_f, n_f;
    logic signed [ghbe_pkg::P_W-1:0]     r_p, n_p;
    logic [2:0]                          r_t, n_t;
    logic signed [ghbe_pkg::WS_W-1:0]    r_cur, n_cur, r_prev, n_prev;
    logic [IW-1:0]                       r_n, n_n;
    logic signed [19:0]                  r_m1hi, n_m1hi;
    logic signed [63:0]                  r_acc, n_acc;
    logic [IW-1:0]                       r_tot, n_tot, r_i, n_i;
    logic [ghbe_pkg::IDX_W-1:0]          r_base, n_base;
    logic                                r_ovalid, n_ovalid;
    logic signed [ghbe_pkg::VAL_W-1:0]   r_obasis, n_obasis;
    logic [ghbe_pkg::IDX_W-1:0]          r_oidx, n_oidx;
    logic                                r_olast, n_olast;

    logic signed [ghbe_pkg::WS_W-1:0]    r_xmem [DEPTH];
    logic signed [ghbe_pkg::WS_W-1:0]    r_ymem [DEPTH];
    logic signed [ghbe_pkg::WS_W-1:0]    r_xrd, r_yrd;

    logic signed [ghbe_pkg::COORD_W-1:0] coord_v;
    logic [3:0]                          ord4;
    logic [21:0]                         coef_a, coef_b;
    logic signed [ghbe_pkg::P_W-1:0]     p_pos;
    logic signed [ghbe_pkg::PROD_W-1:0]  t_rnd;
    logic signed [26:0]                  t_sub;
    logic [47:0]                         seed_sh;
    logic [7:0]                          seed_amt;
    logic signed [ghbe_pkg::WS_W-1:0]    seed_val;
    logic signed [63:0]                  acc_fin, acc_rs;
    logic signed [ghbe_pkg::WS_W-1:0]    rec_val;
    logic signed [ghbe_pkg::PROD_W-1:0]  e_rs;
    logic signed [ghbe_pkg::VAL_W-1:0]   e_val;
    logic                                out_free;
    logic                                w_en;
    logic [IW-1:0]                       w_addr;
    logic signed [ghbe_pkg::WS_W-1:0]    w_data;
    logic                                axis_done;

    assign coord_v = r_ax ? r_y : r_x;
    assign ord4    = 4'(r_n);
    assign coef_a  = ghbe_pkg::rom_a(ord4);
    assign coef_b  = ghbe_pkg::rom_b(ord4);
    assign p_pos   = r_p[ghbe_pkg::P_W-1] ? '0 : r_p;

    // Taylor step: c - round(p*f / 2^16).
    assign t_rnd = (i_mul_p + 57'sd32768) >>> 16;
    assign t_sub = $signed({2'b00, ghbe_pkg::taylor_c(r_t)}) - t_rnd[26:0];

    // Seed scaling by 2^-(24+k) with rounding done as ((x >> (sh-1)) + 1) >> 1.
    assign seed_amt = 8'(r_k) + 8'd23;
    assign seed_sh  = i_mul_p[47:0] >> seed_amt;
    assign seed_val = (r_k >= 7'd39) ? '0 : 24'((seed_sh + 48'd1) >> 1);

    // Recurrence result: the rounding half was added when the sum was started.
    assign acc_fin = r_acc - (64'(i_mul_p) <<< 12);
    assign acc_rs  = acc_fin >>> 32;
    always_comb begin
        if (acc_rs > 64'sd8388607) begin
            rec_val = 24'sh7FFFFF;
        end else if (acc_rs < -64'sd8388608) begin
            rec_val = 24'sh800000;
        end else begin
            rec_val = acc_rs[23:0];
        end
    end

    assign e_rs = (i_mul_p + 57'sd268435456) >>> 29;
    always_comb begin
        if (e_rs > 57'sd32767) begin
            e_val = 16'sh7FFF;
        end else if (e_rs < -57'sd32768) begin
            e_val = 16'sh8000;
        end else begin
            e_val = e_rs[15:0];
        end
    end

    assign out_free = !r_ovalid || o_out.ready;

    always_comb begin
        o_mul_req.a = '0;
        o_mul_req.b = '0;
        case (r_state)
            S_SQ: begin
                o_mul_req.a = 33'(coord_v);
                o_mul_req.b = 24'(coord_v);
            end
            S_LOG: begin
                o_mul_req.a = $signed({2'b00, i_mul_p[30:0]});
                o_mul_req.b = ghbe_pkg::HALF_LOG2E;
            end
            S_TMUL: begin
                o_mul_req.a = 33'(r_p);
                o_mul_req.b = $signed({8'd0, r_f});
            end
            S_SMUL: begin
                o_mul_req.a = $signed({7'd0, p_pos});
                o_mul_req.b = ghbe_pkg::NORM_Q22;
            end
            S_R1: begin
                o_mul_req.a = 33'(coord_v);
                o_mul_req.b = r_cur;
            end
            S_R2: begin
                o_mul_req.a = $signed({13'd0, i_mul_p[19:0]});
                o_mul_req.b = $signed({2'b00, coef_a});
            end
            S_R3: begin
                o_mul_req.a = 33'(r_m1hi);
                o_mul_req.b = $signed({2'b00, coef_a});
            end
            S_R4: begin
                o_mul_req.a = 33'(r_prev);
                o_mul_req.b = $signed({2'b00, coef_b});
            end
            S_EMUL, S_EOUT: begin
                // Held in the output state so that a stall keeps the product.
                o_mul_req.a = 33'(r_xrd);
                o_mul_req.b = r_yrd;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_y      = r_y;
        n_ax     = r_ax;
        n_order  = r_order;
        n_k      = r_k;
        n_f      = r_f;
        n_p      = r_p;
        n_t      = r_t;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_n      = r_n;
        n_m1hi   = r_m1hi;
        n_acc    = r_acc;
        n_tot    = r_tot;
        n_i      = r_i;
        n_base   = r_base;
        n_ovalid = r_ovalid && !o_out.ready;
        n_obasis = r_obasis;
        n_oidx   = r_oidx;
        n_olast  = r_olast;
        w_en     = 1'b0;
        w_addr   = r_n;
        w_data   = rec_val;
        axis_done = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_x  = i_in.x_coord;
                    n_y  = i_in.y_coord;
                    n_ax = 1'b0;
                    if (i_order > 4'(MAX_ORDER)) begin
                        n_order = IW'(MAX_ORDER);
                    end else begin
                        n_order = IW'(i_order);
                    end
                    n_state = S_SQ;
                end
            end
            S_SQ: n_state = S_LOG;
            S_LOG: n_state = S_UF;
            S_UF: begin
                n_k     = i_mul_p[46:40];
                n_f     = i_mul_p[39:24];
                n_p     = $signed({1'b0, ghbe_pkg::taylor_c(3'd7)});
                n_t     = 3'd6;
                n_state = S_TMUL;
            end
            S_TMUL: n_state = S_TACC;
            S_TACC: begin
                n_p = t_sub[ghbe_pkg::P_W-1:0];
                if (r_t == 3'd0) begin
                    n_state = S_SMUL;
                end else begin
                    n_t     = r_t - 3'd1;
                    n_state = S_TMUL;
                end
            end
            S_SMUL: n_state = S_SEED;
            S_SEED: begin
                w_en   = 1'b1;
                w_addr = '0;
                w_data = seed_val;
                n_cur  = seed_val;
                n_prev = '0;
                n_n    = IW'(1);
                if (r_order == '0) begin
                    axis_done = 1'b1;
                end else begin
                    n_state = S_R1;
                end
            end
            S_R1: n_state = S_R2;
            S_R2: begin
                n_m1hi  = i_mul_p[39:20];
                n_state = S_R3;
            end
            S_R3: begin
                n_acc   = 64'(i_mul_p) + 64'sh80000000;
                n_state = S_R4;
            end
            S_R4: begin
                n_acc   = r_acc + (64'(i_mul_p) <<< 20);
                n_state = S_R5;
            end
            S_R5: begin
                w_en   = 1'b1;
                n_prev = r_cur;
                n_cur  = rec_val;
                if (r_n == r_order) begin
                    axis_done = 1'b1;
                end else begin
                    n_n     = r_n + IW'(1);
                    n_state = S_R1;
                end
            end
            S_EPRE: n_state = S_EMUL;
            S_EMUL: n_state = S_EOUT;
            S_EOUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_obasis = e_val;
                    n_oidx   = r_base + 6'(r_i);
                    n_olast  = (r_i == r_tot) && (r_tot == r_order);
                    n_state  = S_EMUL;
                    if (r_i == r_tot) begin
                        if (r_tot == r_order) begin
                            n_state = S_IDLE;
                        end else begin
                            n_base = r_base + 6'(r_tot) + 6'd1;
                            n_tot  = r_tot + IW'(1);
                            n_i    = '0;
                        end
                    end else begin
                        n_i = r_i + IW'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (axis_done) begin
            if (!r_ax) begin
                n_ax    = 1'b1;
                n_state = S_SQ;
            end else begin
                n_tot   = '0;
                n_i     = '0;
                n_base  = '0;
                n_state = S_EPRE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_tot    <= '0;
            r_i      <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_tot    <= n_tot;
            r_i      <= n_i;
        end
        r_x      <= n_x;
        r_y      <= n_y;
        r_ax     <= n_ax;
        r_order  <= n_order;
        r_k      <= n_k;
        r_f      <= n_f;
        r_p      <= n_p;
        r_t      <= n_t;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_n      <= n_n;
        r_m1hi   <= n_m1hi;
        r_acc    <= n_acc;
        r_base   <= n_base;
        r_obasis <= n_obasis;
        r_oidx   <= n_oidx;
        r_olast  <= n_olast;
    end

    // Workspaces: one write port, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_ax) begin
                r_ymem[w_addr] <= w_data;
            end else begin
                r_xmem[w_addr] <= w_data;
            end
        end
        r_xrd <= r_xmem[n_i];
        r_yrd <= r_ymem[n_tot - n_i];
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ovalid;
    assign o_out.basis_value   = r_obasis;
    assign o_out.packed_index  = r_oidx;
    assign o_out.last_of_point = r_olast;

endmodule
